// ===== rtl/ffa_pkg.sv =====
// Shared widths, codes and types of the first-fit heap allocator.
`default_nettype none

package ffa_pkg;

  // Field widths of the channels and the configuration register.
  localparam int REQ_W    = 12;
  localparam int OFF_W    = 12;
  localparam int STATUS_W = 2;
  localparam int BLKS_W   = 11;
  localparam int BYTES_W  = 13;
  localparam int CFG_W    = 13;

  // Width of the block size kept in each header.
  localparam int SIZE_W = 13;

  // Heap size after reset.
  localparam logic [CFG_W-1:0] HEAP_RESET = CFG_W'(4096);

  // Request kinds.
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TOTAL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOFIT = 2'd2;

  // How a walk ended.
  typedef enum logic [1:0] {
    FIT_NEW   = 2'd0,
    FIT_NONE  = 2'd1,
    FIT_REUSE = 2'd2
  } fit_t;

  // One block header as it sits in the header store.
  typedef struct packed {
    logic              used;
    logic [SIZE_W-1:0] size;
  } hdr_entry_t;

endpackage

`default_nettype wire

// ===== rtl/ffa_if.sv =====
// Request and result channel interfaces of the first-fit heap allocator.
`default_nettype none

interface ffa_in_if import ffa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             kind;
  logic [REQ_W-1:0] request_bytes;
  logic [OFF_W-1:0] block_offset;

  modport source (output valid, kind, request_bytes, block_offset, input ready);
  modport sink   (input valid, kind, request_bytes, block_offset, output ready);
endinterface

interface ffa_out_if import ffa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [OFF_W-1:0]    payload_offset;
  logic [BLKS_W-1:0]   blocks_in_use;
  logic [BYTES_W-1:0]  bytes_in_use;

  modport source (output valid, status, payload_offset, blocks_in_use, bytes_in_use,
                  input ready);
  modport sink   (input valid, status, payload_offset, blocks_in_use, bytes_in_use,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/ffa_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module ffa_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/first_fit_heap_allocator_unit.sv =====
// Top level of the first-fit heap allocator: sequencer, shared adder and header store.
//
// Channel  | Dir | Beat contents                                   | Handshake
// ---------+-----+-------------------------------------------------+-------------
// in_ch    | in  | kind, request_bytes, block_offset               | valid/ready
// out_ch   | out | status, payload_offset, blocks_in_use, bytes... | valid/ready
// cfg      | in  | cfg_wr_data = heap_bytes                        | cfg_wr_en
//
// A free holds the sequencer through an address step and an evaluation step (the latter
// skipped when the offset cannot name a header inside the heap), and an allocate refused
// over the free total holds it through a reserve step and a check step. Any other
// allocate then walks the headers: each header costs one read of the header store and
// two passes through the shared adder, and a grant adds a commit step. Every request
// ends in a reply step, and the result beat goes valid at the edge that ends it.
// Reset and every heap_bytes write start a clearing pass over all HEAP_BYTES entries
// of the header store, during which in_ch.ready stays low.
// A finished result waits in the output register; the next beat is accepted
// meanwhile, and only the following result waits for out_ch.ready.
`default_nettype none

module first_fit_heap_allocator_unit import ffa_pkg::*; #(
  parameter int HEAP_BYTES   = 4096,
  parameter int HEADER_BYTES = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_wr_en,
  input  wire logic [CFG_W-1:0] cfg_wr_data,
  ffa_in_if.sink                in_ch,
  ffa_out_if.source             out_ch
);

  // Address width of the header store, and a working width that holds any
  // heap offset plus a block size plus a request without overflow.
  localparam int AW = $clog2(HEAP_BYTES);
  localparam int WW = ((AW > SIZE_W) ? AW : SIZE_W) + 2;
  localparam int EW = $bits(hdr_entry_t);
  localparam logic [WW-1:0] HDR_W  = WW'(HEADER_BYTES);
  localparam logic [WW-1:0] HEAP_W = WW'(HEAP_BYTES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(HEAP_BYTES - 1);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RESV,
    S_CHECK,
    S_TEST,
    S_EVAL,
    S_COMMIT,
    S_FREE_ADDR,
    S_FREE_EVAL,
    S_REPLY
  } state_t;

  state_t state;

  logic [CFG_W-1:0]    heap_reg;
  logic [AW-1:0]       clr_addr;
  logic [REQ_W-1:0]    req_q;
  logic [OFF_W-1:0]    boff_q;
  logic [WW-1:0]       need;
  logic [WW-1:0]       resv;
  logic [WW-1:0]       p;
  logic [WW-1:0]       blk_cnt;
  logic [WW-1:0]       alloc_b;
  logic [SIZE_W-1:0]   ent_size;
  fit_t                fit;
  logic [STATUS_W-1:0] status_q;
  logic [OFF_W-1:0]    grant_q;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [OFF_W-1:0]    out_offset;
  logic [BLKS_W-1:0]   out_blocks;
  logic [BYTES_W-1:0]  out_bytes;

  logic [WW-1:0] h_w;
  logic [WW-1:0] alu_a;
  logic [WW-1:0] alu_b;
  logic [WW-1:0] alu_sum;
  logic          sum_gt_h;
  logic          h_gt_sum;
  logic          boff_ok;
  logic [WW-1:0] payload;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  hdr_entry_t    ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdq;
  hdr_entry_t    rd_ent;

  // The effective heap is the register value, capped at the store size.
  always_comb begin
    if (WW'(heap_reg) > HEAP_W) begin
      h_w = HEAP_W;
    end else begin
      h_w = WW'(heap_reg);
    end
  end

  // The shared adder and its compare against the heap limit. Each sequencer
  // step feeds it the operands that step needs.
  always_comb begin
    alu_a = '0;
    alu_b = '0;
    unique case (state)
      S_RESV: begin
        alu_a = alloc_b;
        alu_b = WW'(blk_cnt * HDR_W);
      end
      S_CHECK: begin
        alu_a = resv;
        alu_b = need;
      end
      S_TEST: begin
        alu_a = p;
        alu_b = need;
      end
      S_EVAL: begin
        alu_a = p;
        alu_b = WW'(rd_ent.size);
      end
      S_COMMIT: begin
        alu_a = alloc_b;
        alu_b = (fit == FIT_NEW) ? WW'(req_q) : WW'(ent_size) - HDR_W;
      end
      S_FREE_ADDR: begin
        alu_a = WW'(boff_q);
        alu_b = WW'(0) - HDR_W;
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  assign alu_sum  = alu_a + alu_b;
  assign sum_gt_h = alu_sum > h_w;
  assign h_gt_sum = h_w > alu_sum;
  assign boff_ok  = WW'(boff_q) >= HDR_W;
  assign payload  = WW'(rd_ent.size) - HDR_W;
  assign rd_ent   = hdr_entry_t'(ram_rdq);

  // Header store control. The walk reads the header at p; a free reads the
  // header in front of the offset straight from the adder.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = p[AW-1:0];
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = p[AW-1:0];
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
      end
      S_TEST: begin
        ram_re = h_gt_sum;
      end
      S_FREE_ADDR: begin
        ram_re    = boff_ok && h_gt_sum;
        ram_raddr = alu_sum[AW-1:0];
      end
      S_COMMIT: begin
        ram_we         = 1'b1;
        ram_wdata.used = 1'b1;
        ram_wdata.size = (fit == FIT_NEW) ? need[SIZE_W-1:0] : ent_size;
      end
      S_FREE_EVAL: begin
        ram_we         = rd_ent.used;
        ram_wdata.used = 1'b0;
        ram_wdata.size = rd_ent.size;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  ffa_ram #(
    .WIDTH (EW),
    .DEPTH (HEAP_BYTES)
  ) u_hdr_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdq)
  );

  // Sequencer. A heap_bytes write drops the counters and restarts the clear.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      blk_cnt   <= '0;
      alloc_b   <= '0;
      heap_reg  <= HEAP_RESET;
      out_valid <= 1'b0;
    end else begin
      // A result taken in the reply step is replaced by the new one below.
      if (out_valid && out_ch.ready && (cfg_wr_en || state != S_REPLY)) begin
        out_valid <= 1'b0;
      end
      if (cfg_wr_en) begin
        heap_reg <= cfg_wr_data;
        state    <= S_CLEAR;
        clr_addr <= '0;
        blk_cnt  <= '0;
        alloc_b  <= '0;
      end else begin
        unique case (state)
          S_CLEAR: begin
            clr_addr <= clr_addr + AW'(1);
            if (clr_addr == LAST_ADDR) begin
              state <= S_IDLE;
            end
          end
          S_IDLE: begin
            if (in_ch.valid) begin
              req_q  <= in_ch.request_bytes;
              boff_q <= in_ch.block_offset;
              need   <= WW'(in_ch.request_bytes) + HDR_W;
              if (in_ch.kind == KIND_FREE) begin
                state <= S_FREE_ADDR;
              end else begin
                state <= S_RESV;
              end
            end
          end
          S_RESV: begin
            resv  <= alu_sum;
            state <= S_CHECK;
          end
          S_CHECK: begin
            // Request plus header against what is left of the heap.
            if (sum_gt_h) begin
              status_q <= ST_TOTAL;
              grant_q  <= '0;
              state    <= S_REPLY;
            end else begin
              p     <= '0;
              state <= S_TEST;
            end
          end
          S_TEST: begin
            if (h_gt_sum) begin
              state <= S_EVAL;
            end else begin
              status_q <= ST_NOFIT;
              grant_q  <= '0;
              state    <= S_REPLY;
            end
          end
          S_EVAL: begin
            ent_size <= rd_ent.size;
            if (!rd_ent.used && rd_ent.size == '0) begin
              fit   <= FIT_NEW;
              state <= S_COMMIT;
            end else if (!rd_ent.used && WW'(rd_ent.size) > need) begin
              fit   <= FIT_REUSE;
              state <= S_COMMIT;
            end else begin
              fit   <= FIT_NONE;
              p     <= alu_sum;
              state <= S_TEST;
            end
          end
          S_COMMIT: begin
            alloc_b  <= alu_sum;
            blk_cnt  <= blk_cnt + WW'(1);
            status_q <= ST_OK;
            grant_q  <= OFF_W'(p + HDR_W);
            state    <= S_REPLY;
          end
          S_FREE_ADDR: begin
            status_q <= ST_OK;
            grant_q  <= '0;
            p        <= alu_sum;
            if (boff_ok && h_gt_sum) begin
              state <= S_FREE_EVAL;
            end else begin
              state <= S_REPLY;
            end
          end
          S_FREE_EVAL: begin
            // Only a header that is in use gives anything back.
            if (rd_ent.used) begin
              if (blk_cnt != '0) begin
                blk_cnt <= blk_cnt - WW'(1);
              end
              alloc_b <= (alloc_b >= payload) ? alloc_b - payload : '0;
            end
            state <= S_REPLY;
          end
          S_REPLY: begin
            if (!out_valid || out_ch.ready) begin
              out_valid  <= 1'b1;
              out_status <= status_q;
              out_offset <= grant_q;
              out_blocks <= blk_cnt[BLKS_W-1:0];
              out_bytes  <= alloc_b[BYTES_W-1:0];
              state      <= S_IDLE;
            end
          end
          default: begin
            state <= S_IDLE;
          end
        endcase
      end
    end
  end

  assign in_ch.ready           = (state == S_IDLE);
  assign out_ch.valid          = out_valid;
  assign out_ch.status         = out_status;
  assign out_ch.payload_offset = out_offset;
  assign out_ch.blocks_in_use  = out_blocks;
  assign out_ch.bytes_in_use   = out_bytes;

  // An accepted beat takes the sequencer out of idle, so in_ch.ready drops.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input accepted twice in a row");

  // A heap size write always restarts the clearing pass.
  a_cfg_clears: assert property (@(posedge clk) disable iff (rst)
    cfg_wr_en |=> (state == S_CLEAR))
    else $error("heap size write did not start a clear");

  // The walk only reads headers that lie inside the heap.
  a_walk_in_heap: assert property (@(posedge clk) disable iff (rst)
    (ram_re && state == S_TEST) |-> (p < h_w))
    else $error("walk read outside the heap");

  // The header store is written only by the clear, a grant or a free.
  a_write_states: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_CLEAR || state == S_COMMIT || state == S_FREE_EVAL))
    else $error("header store written in a wrong step");

  // A failed request never carries an offset.
  a_fail_no_offset: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.status != ST_OK) |-> (out_ch.payload_offset == '0))
    else $error("failed request returned an offset");

endmodule

`default_nettype wire
